// File: design/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg: shared types and codes for the indexed list engine
// Command and status codes, control state and the per-cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package ilid_pkg;

	// command codes; the unused code behaves as a read
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// control sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_SCAN = 2'd1,
		S_DONE = 2'd2
	} state_t;

	// control group broadcast to every cell
	typedef struct packed {
		logic shift_up;    // insert: cells at or above the position move up
		logic shift_down;  // delete: cells at or above the position move down
		logic pick_keep;   // scan picks the entry held before the update
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell: one storage cell of the list row
// Holds one entry, shifts with its neighbors on insert and delete, and
// forwards running largest, smallest, picked and last values to the right.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_cell
	import ilid_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int WORD_WIDTH = 32,
	parameter int IDX        = 0
) (
	input  wire                             clk,
	input  cell_ctrl_t                      ctrl,
	input  wire  [$clog2(CAPACITY+1)-1:0]   upd_pos,
	input  wire  signed [WORD_WIDTH-1:0]    ins_value,
	input  wire  signed [WORD_WIDTH-1:0]    left_val,
	input  wire  signed [WORD_WIDTH-1:0]    right_val,
	input  wire  [$clog2(CAPACITY+1)-1:0]   scan_pos,
	input  wire  [$clog2(CAPACITY+1)-1:0]   scan_cnt,
	input  wire  signed [WORD_WIDTH-1:0]    max_in,
	input  wire  signed [WORD_WIDTH-1:0]    min_in,
	input  wire  signed [WORD_WIDTH-1:0]    pick_in,
	input  wire  signed [WORD_WIDTH-1:0]    last_in,
	output logic signed [WORD_WIDTH-1:0]    val,
	output logic signed [WORD_WIDTH-1:0]    max_o,
	output logic signed [WORD_WIDTH-1:0]    min_o,
	output logic signed [WORD_WIDTH-1:0]    pick_o,
	output logic signed [WORD_WIDTH-1:0]    last_o
);

	localparam int PW = $clog2(CAPACITY + 1);
	localparam logic [PW-1:0] MY_IDX = PW'(IDX);

	logic signed [WORD_WIDTH-1:0] val_q;
	logic signed [WORD_WIDTH-1:0] keep_q;
	logic signed [WORD_WIDTH-1:0] max_q, min_q, pick_q, last_q;
	logic signed [WORD_WIDTH-1:0] max_d, min_d, pick_d, last_d;
	logic                         occupied;

	// shift the entry on insert or delete; keep the old entry for delete reads
	always_ff @(posedge clk) begin
		if (ctrl.shift_down) begin
			keep_q <= val_q;
		end
		if (ctrl.shift_up) begin
			if (MY_IDX == upd_pos) begin
				val_q <= ins_value;
			end else if (MY_IDX > upd_pos) begin
				val_q <= left_val;
			end
		end else if (ctrl.shift_down) begin
			if (MY_IDX >= upd_pos) begin
				val_q <= right_val;
			end
		end
	end

	// fold this entry into the values travelling down the row
	always_comb begin
		occupied = MY_IDX < scan_cnt;
		max_d    = max_in;
		min_d    = min_in;
		pick_d   = pick_in;
		last_d   = last_in;
		if (occupied) begin
			if (IDX == 0) begin
				max_d = val_q;
				min_d = val_q;
			end else begin
				if (max_in < val_q) begin
					max_d = val_q;
				end
				if (val_q < min_in) begin
					min_d = val_q;
				end
			end
			if (MY_IDX == scan_cnt - PW'(1)) begin
				last_d = val_q;
			end
		end
		// a deleted last entry sits beyond the new count, so pick regardless
		if (MY_IDX == scan_pos) begin
			pick_d = ctrl.pick_keep ? keep_q : val_q;
		end
	end

	// advance the running values one cell per cycle
	always_ff @(posedge clk) begin
		max_q  <= max_d;
		min_q  <= min_d;
		pick_q <= pick_d;
		last_q <= last_d;
	end

	assign val    = val_q;
	assign max_o  = max_q;
	assign min_o  = min_q;
	assign pick_o = pick_q;
	assign last_o = last_q;

endmodule

`default_nettype wire

// File: design/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: bounded ordered list of signed words
// A row of cells holds the list; commands insert, delete or read by position.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid / cmd_stall) carries op, position and value.
//   Response channel (rsp_valid / rsp_stall) carries status, read_value,
//   count and the first, last, largest and smallest entries after the command.
//   Insert and delete shift the whole cell row in the cycle the transaction is
//   accepted. Largest, smallest, the addressed entry and the last entry then
//   travel down the row one cell per cycle, and the response is loaded from
//   the tail of the row once the scan has reached the last cell.
//   One command is in flight at a time: a new command is accepted only after
//   the previous response has been loaded into the output register.
//   The response sits in an output register; while the receiver stalls it
//   holds, and a finished next result waits in the sequencer until it drains.
//   Reset empties the list (count zero) and drops any pending response;
//   entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_delete
	import ilid_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int WORD_WIDTH = 32
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cmd_valid,
	output logic                            cmd_stall,
	input  wire  [1:0]                      op,
	input  wire  [$clog2(CAPACITY+1)-1:0]   position,
	input  wire  signed [WORD_WIDTH-1:0]    value,
	output logic                            rsp_valid,
	input  wire                             rsp_stall,
	output logic [1:0]                      status,
	output logic signed [WORD_WIDTH-1:0]    read_value,
	output logic [$clog2(CAPACITY+1)-1:0]   count,
	output logic signed [WORD_WIDTH-1:0]    first_entry,
	output logic signed [WORD_WIDTH-1:0]    last_entry,
	output logic signed [WORD_WIDTH-1:0]    largest,
	output logic signed [WORD_WIDTH-1:0]    smallest
);

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int SW = $clog2(CAPACITY);
	localparam logic [PW-1:0] FULL_COUNT = PW'(CAPACITY);
	localparam logic [SW-1:0] SCAN_LAST  = SW'(CAPACITY - 1);

	state_t                       state_q, state_d;
	logic [SW-1:0]                scan_q;
	logic [PW-1:0]                cnt_q;
	logic [PW-1:0]                pos_q;
	status_t                      status_q;
	logic                         is_insert_q;
	logic                         keep_q;
	logic signed [WORD_WIDTH-1:0] ins_val_q;

	logic                         cmd_accept;
	logic                         rsp_free;
	logic                         load_rsp;
	status_t                      status_d;
	logic                         is_insert;
	cell_ctrl_t                   ctrl;

	logic signed [WORD_WIDTH-1:0] val_w  [CAPACITY];
	logic signed [WORD_WIDTH-1:0] max_w  [CAPACITY];
	logic signed [WORD_WIDTH-1:0] min_w  [CAPACITY];
	logic signed [WORD_WIDTH-1:0] pick_w [CAPACITY];
	logic signed [WORD_WIDTH-1:0] last_w [CAPACITY];

	logic                         rsp_valid_q;
	logic [1:0]                   status_out_q;
	logic signed [WORD_WIDTH-1:0] read_value_q, first_q, last_q, largest_q, smallest_q;
	logic [PW-1:0]                count_q;

	assign cmd_accept = cmd_valid && !cmd_stall;
	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign is_insert  = op_t'(op) == OP_INSERT;

	// check the command against the current count
	always_comb begin
		status_d = ST_OK;
		if (is_insert) begin
			if (cnt_q == FULL_COUNT) begin
				status_d = ST_FULL;
			end else if (position > cnt_q) begin
				status_d = ST_RANGE;
			end
		end else begin
			if (cnt_q == '0) begin
				status_d = ST_EMPTY;
			end else if (position >= cnt_q) begin
				status_d = ST_RANGE;
			end
		end
	end

	// drive the cell row controls
	always_comb begin
		ctrl.shift_up   = cmd_accept && status_d == ST_OK && is_insert;
		ctrl.shift_down = cmd_accept && status_d == ST_OK && op_t'(op) == OP_DELETE;
		ctrl.pick_keep  = keep_q;
	end

	// sequence accept, scan and response load
	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		load_rsp  = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_q == SCAN_LAST) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_accept) begin
				scan_q <= '0;
				if (ctrl.shift_up) begin
					cnt_q <= cnt_q + PW'(1);
				end else if (ctrl.shift_down) begin
					cnt_q <= cnt_q - PW'(1);
				end
			end else if (state_q == S_SCAN) begin
				scan_q <= scan_q + SW'(1);
			end
		end
	end

	// hold the command for the scan
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			pos_q       <= position;
			status_q    <= status_d;
			is_insert_q <= is_insert;
			keep_q      <= op_t'(op) == OP_DELETE;
			ins_val_q   <= value;
		end
	end

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [WORD_WIDTH-1:0] left_v, right_v, max_i, min_i, pick_i, last_i;
		if (i == 0) begin : g_head
			assign left_v = value;
			assign max_i  = '0;
			assign min_i  = '0;
			assign pick_i = '0;
			assign last_i = '0;
		end else begin : g_body
			assign left_v = val_w[i-1];
			assign max_i  = max_w[i-1];
			assign min_i  = min_w[i-1];
			assign pick_i = pick_w[i-1];
			assign last_i = last_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_v = val_w[i];
		end else begin : g_mid
			assign right_v = val_w[i+1];
		end

		ilid_cell #(
			.CAPACITY   (CAPACITY),
			.WORD_WIDTH (WORD_WIDTH),
			.IDX        (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.upd_pos   (position),
			.ins_value (value),
			.left_val  (left_v),
			.right_val (right_v),
			.scan_pos  (pos_q),
			.scan_cnt  (cnt_q),
			.max_in    (max_i),
			.min_in    (min_i),
			.pick_in   (pick_i),
			.last_in   (last_i),
			.val       (val_w[i]),
			.max_o     (max_w[i]),
			.min_o     (min_w[i]),
			.pick_o    (pick_w[i]),
			.last_o    (last_w[i])
		);
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload: summaries from the tail of the row, first entry from the head
	always_ff @(posedge clk) begin
		if (load_rsp) begin
			status_out_q <= status_q;
			count_q      <= cnt_q;
			if (status_q != ST_OK) begin
				read_value_q <= '1;
			end else if (is_insert_q) begin
				read_value_q <= ins_val_q;
			end else begin
				read_value_q <= pick_w[CAPACITY-1];
			end
			if (cnt_q == '0) begin
				first_q    <= '1;
				last_q     <= '1;
				largest_q  <= '1;
				smallest_q <= '1;
			end else begin
				first_q    <= val_w[0];
				last_q     <= last_w[CAPACITY-1];
				largest_q  <= max_w[CAPACITY-1];
				smallest_q <= min_w[CAPACITY-1];
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_out_q;
	assign read_value  = read_value_q;
	assign count       = count_q;
	assign first_entry = first_q;
	assign last_entry  = last_q;
	assign largest     = largest_q;
	assign smallest    = smallest_q;

endmodule

`default_nettype wire

// File: design/ilid_checker.sv
// ----------------------------------------------------------------------------
// ilid_checker: port-level checks for the indexed list engine
// Watches the response channel for consistent list summaries.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_checker
	import ilid_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int WORD_WIDTH = 32
) (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             rsp_valid,
	input wire                             rsp_stall,
	input wire [1:0]                       status,
	input wire signed [WORD_WIDTH-1:0]     read_value,
	input wire [$clog2(CAPACITY+1)-1:0]    count,
	input wire signed [WORD_WIDTH-1:0]     first_entry,
	input wire signed [WORD_WIDTH-1:0]     largest,
	input wire signed [WORD_WIDTH-1:0]     smallest
);

	localparam int PW = $clog2(CAPACITY + 1);

	// count never exceeds the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> count <= PW'(CAPACITY))
		else $error("count above capacity");

	// a rejected transaction reads back all ones
	a_reject_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_OK) |-> read_value == '1)
		else $error("rejected transaction returned a value");

	// a non-empty list has ordered extremes bracketing the first entry
	a_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && count != '0) |->
			(smallest <= largest && smallest <= first_entry && first_entry <= largest))
		else $error("largest or smallest inconsistent");

	// full and empty status match the reported count
	a_status_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == ST_FULL || status == ST_EMPTY)) |->
			((status == ST_FULL && count == PW'(CAPACITY)) ||
			 (status == ST_EMPTY && count == '0)))
		else $error("status disagrees with count");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(read_value) && $stable(count)))
		else $error("stalled response changed");

endmodule

bind indexed_list_insert_delete ilid_checker #(
	.CAPACITY   (CAPACITY),
	.WORD_WIDTH (WORD_WIDTH)
) u_ilid_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.status      (status),
	.read_value  (read_value),
	.count       (count),
	.first_entry (first_entry),
	.largest     (largest),
	.smallest    (smallest)
);

`default_nettype wire

// File: test/tb_indexed_list_insert_delete.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_delete: self-checking bench for the indexed list
// Drives insert, delete and read commands through the valid/stall command
// channel and predicts each response from a shadow list kept in the bench.
// A directed opening covers empty and out-of-range corners. Random fill
// and drain phases follow. The response side stalls in changing patterns and
// holds off for long stretches so that the engine backs up into its input.
// ----------------------------------------------------------------------------

module tb_indexed_list_insert_delete;
	import ilid_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int WORD_W      = 32;
	localparam int POS_W       = $clog2(CAPACITY + 1);
	localparam int RANDOM_CMDS = 950;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		op_t                      op;
		logic [POS_W-1:0]         position;
		logic signed [WORD_W-1:0] value;
	} list_cmd_t;

	typedef struct packed {
		status_t                  status;
		logic signed [WORD_W-1:0] read_value;
		logic [POS_W-1:0]         count;
		logic signed [WORD_W-1:0] first_entry;
		logic signed [WORD_W-1:0] last_entry;
		logic signed [WORD_W-1:0] largest;
		logic signed [WORD_W-1:0] smallest;
	} list_rsp_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cmd_valid = 1'b0;
	logic                     cmd_stall;
	op_t                      cmd_op = OP_READ;
	logic [POS_W-1:0]         cmd_position = '0;
	logic signed [WORD_W-1:0] cmd_value = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	logic [1:0]               rsp_status;
	logic signed [WORD_W-1:0] rsp_read_value;
	logic [POS_W-1:0]         rsp_count;
	logic signed [WORD_W-1:0] rsp_first;
	logic signed [WORD_W-1:0] rsp_last;
	logic signed [WORD_W-1:0] rsp_largest;
	logic signed [WORD_W-1:0] rsp_smallest;

	list_cmd_t pending_cmds[$];
	list_rsp_t expected_rsps[$];

	// shadow list of the engine
	logic signed [WORD_W-1:0] list_words[CAPACITY];
	int                       list_len = 0;

	// entry count as the stimulus generator sees it
	int gen_len = 0;

	logic cmd_fire = 1'b0;
	int   fail_count = 0;
	int   rsp_index = 0;
	int   cycle_count = 0;
	int   burst_left = 0;
	int   gap_left = 0;
	int   stall_clock = 0;
	int   stall_phase_left = 0;
	int   stall_pct = 0;

	indexed_list_insert_delete #(
		.CAPACITY   (CAPACITY),
		.WORD_WIDTH (WORD_W)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.op          (cmd_op),
		.position    (cmd_position),
		.value       (cmd_value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (rsp_status),
		.read_value  (rsp_read_value),
		.count       (rsp_count),
		.first_entry (rsp_first),
		.last_entry  (rsp_last),
		.largest     (rsp_largest),
		.smallest    (rsp_smallest)
	);

	// apply one command to the shadow list and build the response it causes
	function automatic list_rsp_t apply_list_command(list_cmd_t c);
		list_rsp_t r;
		int        p;
		int        i;
		p = c.position;
		r.status = ST_OK;
		r.read_value = -1;
		case (c.op)
			OP_INSERT: begin
				if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (p > list_len) begin
					r.status = ST_RANGE;
				end else begin
					for (i = list_len; i > p; i--)
						list_words[i] = list_words[i-1];
					list_words[p] = c.value;
					list_len++;
					r.read_value = c.value;
				end
			end
			OP_DELETE: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else if (p >= list_len) begin
					r.status = ST_RANGE;
				end else begin
					r.read_value = list_words[p];
					for (i = p; i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			// read, and the reserved code that acts as one
			default: begin
				if (list_len == 0)
					r.status = ST_EMPTY;
				else if (p >= list_len)
					r.status = ST_RANGE;
				else
					r.read_value = list_words[p];
			end
		endcase
		r.count = POS_W'(list_len);
		if (list_len == 0) begin
			r.first_entry = -1;
			r.last_entry  = -1;
			r.largest     = -1;
			r.smallest    = -1;
		end else begin
			r.first_entry = list_words[0];
			r.last_entry  = list_words[list_len-1];
			r.largest     = list_words[0];
			r.smallest    = list_words[0];
			for (i = 1; i < list_len; i++) begin
				if (list_words[i] > r.largest)
					r.largest = list_words[i];
				if (list_words[i] < r.smallest)
					r.smallest = list_words[i];
			end
		end
		return r;
	endfunction

	// queue a command and track the entry count it leaves behind
	task automatic push_cmd(input op_t o, input int p, input logic signed [WORD_W-1:0] v);
		list_cmd_t c;
		c.op = o;
		c.position = POS_W'(p);
		c.value = v;
		pending_cmds.push_back(c);
		if (o == OP_INSERT && gen_len < CAPACITY && p <= gen_len)
			gen_len++;
		else if (o == OP_DELETE && gen_len > 0 && p < gen_len)
			gen_len--;
	endtask

	// mostly valid positions, weighted to the ends, with some just past or far out
	function automatic int pick_position(op_t o);
		int limit;
		int roll;
		limit = (o == OP_INSERT) ? gen_len : gen_len - 1;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return $urandom_range(0, 31);
		if (roll < 15)
			return limit + 1;
		if (limit < 0 || roll < 35)
			return 0;
		if (roll < 55)
			return limit;
		return $urandom_range(0, limit);
	endfunction

	// extremes and near-ties often, full-range words otherwise
	function automatic logic signed [WORD_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return {1'b1, {(WORD_W-1){1'b0}}};
		if (roll < 16)
			return {1'b0, {(WORD_W-1){1'b1}}};
		if (roll < 22)
			return -1;
		if (roll < 26)
			return 0;
		if (roll < 45)
			return $signed($urandom_range(0, 6)) - 3;
		return $urandom;
	endfunction

	task automatic check_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= 10)
				$display("response %0d: %s expected %h, got %h", rsp_index, name, want, got);
		end
	endtask

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// stimulus, reset and end of run
	initial begin
		int               fill_bias;
		int               roll;
		op_t              o;
		logic signed [WORD_W-1:0] int_min;
		logic signed [WORD_W-1:0] int_max;
		int_min = {1'b1, {(WORD_W-1){1'b0}}};
		int_max = {1'b0, {(WORD_W-1){1'b1}}};

		// empty list corners
		push_cmd(OP_READ, 0, 0);
		push_cmd(OP_DELETE, 0, 0);
		push_cmd(OP_RSVD, 0, 0);
		push_cmd(OP_INSERT, 1, 7);
		// build a short list at front, end and middle
		push_cmd(OP_INSERT, 0, int_max);
		push_cmd(OP_INSERT, 1, int_min);
		push_cmd(OP_INSERT, 0, -1);
		push_cmd(OP_INSERT, 1, 0);
		push_cmd(OP_READ, 0, 0);
		push_cmd(OP_READ, 3, 0);
		// positions past the end, and a reserved-code read in range
		push_cmd(OP_READ, 4, 0);
		push_cmd(OP_READ, 31, 0);
		push_cmd(OP_RSVD, 2, 0);
		push_cmd(OP_DELETE, 4, 0);
		push_cmd(OP_DELETE, 31, 0);
		push_cmd(OP_INSERT, 5, 1);
		push_cmd(OP_INSERT, 31, 32'h5555_5555);
		// delete first, last, append, delete middle
		push_cmd(OP_DELETE, 0, 0);
		push_cmd(OP_DELETE, 2, 0);
		push_cmd(OP_INSERT, 2, 32'haaaa_aaaa);
		push_cmd(OP_DELETE, 1, 0);

		// random fill and drain phases
		fill_bias = 75;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (gen_len == CAPACITY && $urandom_range(0, 3) == 0)
				fill_bias = 25;
			if (gen_len == 0)
				fill_bias = 75;
			if ($urandom_range(0, 39) == 0)
				fill_bias = $urandom_range(20, 80);
			roll = $urandom_range(0, 99);
			if (roll < 5)
				o = OP_RSVD;
			else if (roll < 20)
				o = OP_READ;
			else if ($urandom_range(0, 99) < fill_bias)
				o = OP_INSERT;
			else
				o = OP_DELETE;
			push_cmd(o, pick_position(o), pick_value());
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// command driver: bursts with random gaps, payload held while stalled
	always @(negedge clk) begin
		if (arst_n) begin
			if (cmd_fire) begin
				void'(pending_cmds.pop_front());
				burst_left--;
			end
			if (!(cmd_valid && !cmd_fire)) begin
				if (burst_left <= 0 && gap_left == 0) begin
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
						: $urandom_range(1, 12);
				end
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					cmd_valid    <= 1'b1;
					cmd_op       <= pending_cmds[0].op;
					cmd_position <= pending_cmds[0].position;
					cmd_value    <= pending_cmds[0].value;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// response stall: phases of differing density plus two long hold-offs
	always @(negedge clk) begin
		if (arst_n) begin
			stall_clock++;
			if (stall_phase_left == 0) begin
				stall_phase_left = $urandom_range(10, 200);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end else begin
				stall_phase_left--;
			end
			if ((stall_clock >= 4000 && stall_clock < 4400)
					|| (stall_clock >= 12000 && stall_clock < 12200))
				rsp_stall <= 1'b1;
			else
				rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// monitor: check each response, then predict each accepted command
	always @(posedge clk or negedge arst_n) begin
		list_rsp_t want;
		list_cmd_t got_cmd;
		if (!arst_n) begin
			cmd_fire <= 1'b0;
		end else begin
			cmd_fire <= cmd_valid && !cmd_stall;
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					check_field("response with none expected, read_value", '0, rsp_read_value);
					if (rsp_read_value === '0)
						check_field("response with none expected", '0, '1);
				end else begin
					want = expected_rsps.pop_front();
					check_field("status", WORD_W'(want.status), WORD_W'(rsp_status));
					check_field("read_value", want.read_value, rsp_read_value);
					check_field("count", WORD_W'(want.count), WORD_W'(rsp_count));
					check_field("first_entry", want.first_entry, rsp_first);
					check_field("last_entry", want.last_entry, rsp_last);
					check_field("largest", want.largest, rsp_largest);
					check_field("smallest", want.smallest, rsp_smallest);
				end
				rsp_index++;
			end
			if (cmd_valid && !cmd_stall) begin
				got_cmd.op = cmd_op;
				got_cmd.position = cmd_position;
				got_cmd.value = cmd_value;
				expected_rsps.push_back(apply_list_command(got_cmd));
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
